### rtl/core/bcv_pkg.sv
// Shared definitions for the breakpoint curve evaluator: sizes, segment
// mode codes, the blend request type and the quarter-sine table.
// No dependencies; every other file in rtl/core uses this package.
`timescale 1ns / 1ps

package bcv_pkg;

  // Number of breakpoints held in the store.
  localparam int MAX_POINTS = 16;
  // Number of intervals in the quarter-sine table (table has one more entry).
  localparam int SINE_ENTRIES = 256;

  localparam int PTR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int TAB_IDX_W = $clog2(SINE_ENTRIES + 1);

  // Field widths fixed by the interface.
  localparam int AMT_W   = 16;
  localparam int WORD_W  = 16;
  localparam int VAL_W   = 14;
  localparam int RATIO_W = 16;
  localparam int SIN_W   = 17;
  localparam int OUT_W   = 22;
  localparam int CFG_W   = 5;
  localparam int ENTRY_W = AMT_W + WORD_W;

  // Segment mode codes, held in the top two bits of a breakpoint word.
  localparam logic [1:0] MODE_SINE = 2'b01;
  localparam logic [1:0] MODE_ZERO = 2'b10;

  // Polynomial coefficients of the table builder, Q32.
  localparam logic [63:0] COEF_A1 = 64'd6746518852;
  localparam logic [63:0] COEF_B3 = 64'd2774394673;
  localparam logic [63:0] COEF_A5 = 64'd342277197;
  localparam logic [63:0] COEF_B7 = 64'd20107981;
  localparam logic [63:0] COEF_A9 = 64'd689072;
  localparam logic [63:0] SIN_ONE = 64'd65536;

  typedef logic [SIN_W-1:0] sine_tab_t [0:SINE_ENTRIES];

  // Request handed from the sequencer to the blend pipeline.
  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [VAL_W-1:0]   v1;
    logic [VAL_W-1:0]   v2;
    logic               sine_mode;
  } blend_req_t;

  // One nested multiply-subtract step of the odd polynomial.
  function automatic logic [63:0] poly_step(input logic [63:0] x2,
                                            input logic [63:0] p,
                                            input logic [63:0] coef);
    logic [63:0] t;
    t = (x2 * p) >> 16;
    return (coef > t) ? coef - t : 64'd0;
  endfunction

  // Quarter sine of x (Q16 of the quarter turn), Q1.16, capped at one.
  function automatic logic [SIN_W-1:0] poly_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] p;
    x2 = (x * x) >> 16;
    p  = COEF_A9;
    p  = poly_step(x2, p, COEF_B7);
    p  = poly_step(x2, p, COEF_A5);
    p  = poly_step(x2, p, COEF_B3);
    p  = poly_step(x2, p, COEF_A1);
    p  = (p * x) >> 32;
    return (p > SIN_ONE) ? SIN_W'(SIN_ONE) : SIN_W'(p);
  endfunction

  // Builds the sine table at elaboration.
  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] x;
    for (int k = 0; k <= SINE_ENTRIES; k++) begin
      x = (64'(k) << 16) / SINE_ENTRIES;
      tab[k] = poly_sine(x);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

### rtl/core/bcv_store.sv
// Breakpoint store: a single-port-write, single-port-read synchronous RAM
// with a registered read port. Depends on bcv_pkg for sizes.
`timescale 1ns / 1ps

module bcv_store (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [bcv_pkg::PTR_W-1:0]   wr_addr,
  input  logic [bcv_pkg::ENTRY_W-1:0] wr_data,
  input  logic [bcv_pkg::PTR_W-1:0]   rd_addr,
  output logic [bcv_pkg::ENTRY_W-1:0] rd_data_r
);

  logic [bcv_pkg::ENTRY_W-1:0] mem [0:bcv_pkg::MAX_POINTS-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

### rtl/core/bcv_div.sv
// Restoring divider producing the Q0.16 segment ratio, one quotient bit
// per cycle. Depends on bcv_pkg for widths.
`timescale 1ns / 1ps

module bcv_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bcv_pkg::AMT_W-1:0]   num_hi,
  input  logic [bcv_pkg::AMT_W-1:0]   den,
  output logic                        done_r,
  output logic [bcv_pkg::RATIO_W-1:0] quot_r
);

  localparam int STEP_W = $clog2(bcv_pkg::RATIO_W + 1);

  logic [bcv_pkg::AMT_W-1:0] rem_r;
  logic [bcv_pkg::AMT_W-1:0] den_r;
  logic [STEP_W-1:0]         cnt_r;
  logic                      act_r;
  logic [bcv_pkg::AMT_W:0]   shifted;
  logic [bcv_pkg::AMT_W:0]   trial;

  // One trial subtraction of the shifted remainder; the remainder always
  // stays below the divisor, so the quotient fits in sixteen bits.
  always_comb begin
    shifted = {rem_r, 1'b0};
    trial   = shifted - {1'b0, den_r};
  end

  // Control: step counter and completion strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        act_r <= 1'b1;
        cnt_r <= STEP_W'(bcv_pkg::RATIO_W);
      end else if (act_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          act_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num_hi;
      den_r  <= den;
      quot_r <= '0;
    end else if (act_r) begin
      if (!trial[bcv_pkg::AMT_W]) begin
        rem_r  <= trial[bcv_pkg::AMT_W-1:0];
        quot_r <= {quot_r[bcv_pkg::RATIO_W-2:0], 1'b1};
      end else begin
        rem_r  <= shifted[bcv_pkg::AMT_W-1:0];
        quot_r <= {quot_r[bcv_pkg::RATIO_W-2:0], 1'b0};
      end
    end
  end

endmodule

### rtl/core/bcv_blend.sv
// Blend pipeline: optional quarter-sine shaping of the ratio, then the
// weighted mix of the two breakpoint values in Q14.8. Depends on bcv_pkg.
`timescale 1ns / 1ps

module bcv_blend (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  bcv_pkg::blend_req_t       req,
  output logic                      done_r,
  output logic [bcv_pkg::OUT_W-1:0] value_r
);

  localparam int PROD_W = bcv_pkg::SIN_W + 16;
  localparam int MIX_W  = bcv_pkg::VAL_W + 1 + bcv_pkg::SIN_W + 1;
  localparam int ACC_W  = bcv_pkg::VAL_W + 24 + 1;

  // Stage 0: table lookup of the two neighbouring sine entries.
  logic [31:0]                    pos;
  logic [bcv_pkg::TAB_IDX_W-1:0]  idx;
  logic [bcv_pkg::SIN_W-1:0]      lo;
  logic [bcv_pkg::SIN_W-1:0]      hi;

  always_comb begin
    pos = 32'(req.ratio) * 32'(bcv_pkg::SINE_ENTRIES);
    idx = bcv_pkg::TAB_IDX_W'(pos >> 16);
    lo  = bcv_pkg::SINE_TAB[idx];
    hi  = bcv_pkg::SINE_TAB[idx + bcv_pkg::TAB_IDX_W'(1)];
  end

  logic                       s1_vld_r;
  logic [bcv_pkg::SIN_W-1:0]  s1_lo_r;
  logic [bcv_pkg::SIN_W-1:0]  s1_diff_r;
  logic [15:0]                s1_frac_r;
  bcv_pkg::blend_req_t        s1_req_r;

  logic                       s2_vld_r;
  logic [bcv_pkg::SIN_W-1:0]  s2_lo_r;
  logic [PROD_W-1:0]          s2_prod_r;
  bcv_pkg::blend_req_t        s2_req_r;

  logic                       s3_vld_r;
  logic [bcv_pkg::VAL_W-1:0]  s3_v1_r;
  logic signed [MIX_W-1:0]    s3_mix_r;

  logic [bcv_pkg::SIN_W-1:0]  weight;
  logic signed [bcv_pkg::VAL_W:0]   delta;
  logic signed [bcv_pkg::SIN_W:0]   weight_s;
  logic signed [ACC_W-1:0]          acc;

  // Stage 2 combinational: finish the sine interpolation and form the
  // signed difference of the values.
  always_comb begin
    if (s2_req_r.sine_mode) begin
      weight = s2_lo_r + bcv_pkg::SIN_W'(s2_prod_r >> 16);
    end else begin
      weight = bcv_pkg::SIN_W'(s2_req_r.ratio);
    end
    delta    = $signed({1'b0, s2_req_r.v2}) - $signed({1'b0, s2_req_r.v1});
    weight_s = $signed({1'b0, weight});
  end

  // Stage 3 combinational: add the scaled first value and truncate.
  always_comb begin
    acc = $signed({1'b0, s3_v1_r, 24'd0}) + ACC_W'(s3_mix_r);
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      s1_vld_r <= start;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      done_r   <= s3_vld_r;
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk) begin
    s1_lo_r   <= lo;
    s1_diff_r <= (hi < lo) ? '0 : hi - lo;
    s1_frac_r <= pos[15:0];
    s1_req_r  <= req;

    s2_lo_r   <= s1_lo_r;
    s2_prod_r <= PROD_W'(s1_diff_r) * PROD_W'(s1_frac_r);
    s2_req_r  <= s1_req_r;

    s3_v1_r   <= s2_req_r.v1;
    s3_mix_r  <= MIX_W'(delta) * MIX_W'(weight_s);

    value_r   <= acc[bcv_pkg::OUT_W+15:16];
  end

endmodule

### rtl/core/breakpoint_curve_evaluator.sv
// Breakpoint curve evaluator: a write never raises busy. An evaluate on an
// empty curve is answered without raising busy, one at a curve end from the
// end checks, and one inside at most through the serial scan, the 16-step
// divider and the 4-stage blend; busy drops in the same cycle as the result
// strobe. Results cannot stall.
// Synchronous active-low reset clears the point count and the sequencer.
`timescale 1ns / 1ps

module breakpoint_curve_evaluator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_req_type,
  input  logic [3:0]                   in_point_index,
  input  logic [bcv_pkg::AMT_W-1:0]    in_point_amount,
  input  logic [bcv_pkg::WORD_W-1:0]   in_point_word,
  input  logic [bcv_pkg::AMT_W-1:0]    in_query_amount,
  output logic                         out_strobe,
  output logic [bcv_pkg::OUT_W-1:0]    out_curve_value,
  input  logic                         cfg_we,
  input  logic [bcv_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK0  = 3'd1;
  localparam logic [2:0] S_CHKN  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_BLEND = 3'd5;

  localparam int AW = bcv_pkg::AMT_W;
  localparam int WW = bcv_pkg::WORD_W;
  localparam int VW = bcv_pkg::VAL_W;
  localparam int OW = bcv_pkg::OUT_W;
  localparam int PW = bcv_pkg::PTR_W;
  localparam int CW = bcv_pkg::CNT_W;

  logic [2:0]                   state_r, state_nxt;
  logic [AW-1:0]                q_r, q_nxt;
  logic [bcv_pkg::ENTRY_W-1:0]  a_r, a_nxt;
  logic [bcv_pkg::ENTRY_W-1:0]  b_r, b_nxt;
  logic [PW-1:0]                j_r, j_nxt;
  logic                         out_strobe_r, out_strobe_nxt;
  logic [OW-1:0]                out_value_r, out_value_nxt;
  logic [bcv_pkg::CFG_W-1:0]    point_count_r;

  logic                         accept;
  logic                         wr_en;
  logic [PW-1:0]                rd_addr;
  logic [bcv_pkg::ENTRY_W-1:0]  rd_data_r;
  logic [CW-1:0]                n_pts;
  logic [PW-1:0]                last;
  logic [AW-1:0]                rd_amt;
  logic [AW-1:0]                a_amt;
  logic [AW-1:0]                b_amt;

  logic                         div_start;
  logic [AW-1:0]                div_num;
  logic [AW-1:0]                div_den;
  logic                         div_done;
  logic [bcv_pkg::RATIO_W-1:0]  div_quot;

  logic                         blend_start;
  bcv_pkg::blend_req_t          blend_req;
  logic                         blend_done;
  logic [OW-1:0]                blend_value;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Points in use, limited to the store depth.
  always_comb begin
    if (int'(point_count_r) > bcv_pkg::MAX_POINTS) begin
      n_pts = CW'(bcv_pkg::MAX_POINTS);
    end else begin
      n_pts = CW'(point_count_r);
    end
    last = PW'(n_pts - CW'(1));
  end

  assign rd_amt = rd_data_r[bcv_pkg::ENTRY_W-1:WW];
  assign a_amt  = a_r[bcv_pkg::ENTRY_W-1:WW];
  assign b_amt  = b_r[bcv_pkg::ENTRY_W-1:WW];

  // Breakpoint writes go straight to the store; out-of-range indexes drop.
  assign wr_en = accept && !in_req_type &&
                 (int'(in_point_index) < bcv_pkg::MAX_POINTS);

  bcv_store u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (PW'(in_point_index)),
    .wr_data   ({in_point_amount, in_point_word}),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data_r)
  );

  assign div_num = q_r - a_amt;
  assign div_den = rd_amt - a_amt;

  bcv_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num_hi (div_num),
    .den    (div_den),
    .done_r (div_done),
    .quot_r (div_quot)
  );

  always_comb begin
    blend_req.ratio     = div_quot;
    blend_req.v1        = a_r[VW-1:0];
    blend_req.v2        = b_r[VW-1:0];
    blend_req.sine_mode = (b_r[WW-1:WW-2] == bcv_pkg::MODE_SINE);
  end

  bcv_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (blend_start),
    .req     (blend_req),
    .done_r  (blend_done),
    .value_r (blend_value)
  );

  // Sequencer: end checks, segment scan, division and blend.
  always_comb begin
    state_nxt      = state_r;
    q_nxt          = q_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    j_nxt          = j_r;
    out_strobe_nxt = 1'b0;
    out_value_nxt  = out_value_r;
    rd_addr        = '0;
    div_start      = 1'b0;
    blend_start    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept && in_req_type) begin
          q_nxt = in_query_amount;
          if (n_pts == '0) begin
            out_strobe_nxt = 1'b1;
            out_value_nxt  = '0;
          end else begin
            state_nxt = S_CHK0;
          end
        end
      end
      S_CHK0: begin
        // First breakpoint is on the read port.
        if (q_r <= rd_amt) begin
          out_strobe_nxt = 1'b1;
          out_value_nxt  = {rd_data_r[VW-1:0], 8'd0};
          state_nxt      = S_IDLE;
        end else begin
          a_nxt     = rd_data_r;
          rd_addr   = last;
          state_nxt = S_CHKN;
        end
      end
      S_CHKN: begin
        // Last breakpoint is on the read port.
        if (q_r >= rd_amt) begin
          out_strobe_nxt = 1'b1;
          out_value_nxt  = {rd_data_r[VW-1:0], 8'd0};
          state_nxt      = S_IDLE;
        end else begin
          rd_addr   = PW'(1);
          j_nxt     = PW'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Breakpoint j is on the read port; advance or close the segment.
        if ((j_r < last) && (q_r >= rd_amt)) begin
          a_nxt   = rd_data_r;
          j_nxt   = j_r + PW'(1);
          rd_addr = j_r + PW'(1);
        end else begin
          b_nxt = rd_data_r;
          if (rd_amt <= a_amt) begin
            out_strobe_nxt = 1'b1;
            out_value_nxt  = '0;
            state_nxt      = S_IDLE;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (b_r[WW-1:WW-2] == bcv_pkg::MODE_ZERO) begin
            out_strobe_nxt = 1'b1;
            out_value_nxt  = '0;
            state_nxt      = S_IDLE;
          end else begin
            blend_start = 1'b1;
            state_nxt   = S_BLEND;
          end
        end
      end
      S_BLEND: begin
        if (blend_done) begin
          out_strobe_nxt = 1'b1;
          out_value_nxt  = blend_value;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_strobe_r  <= 1'b0;
      point_count_r <= '0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        point_count_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    q_r         <= q_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    j_r         <= j_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_curve_value = out_value_r;

endmodule

### tb/sv/breakpoint_curve_evaluator_tb.sv
// Self-checking testbench for the breakpoint curve evaluator: breakpoint writes,
// curve evaluations and point-count changes against a scoreboard with its own curve model.
// Depends on bcv_pkg and breakpoint_curve_evaluator from rtl/core.
`timescale 1ns / 1ps

module breakpoint_curve_evaluator_tb;

  localparam int RANDOM_ITEMS = 1700;
  localparam int IDLE_PCT     = 12;
  localparam int SETTLE       = 60;
  localparam int RUN_LIMIT    = 2000000;

  // Segment modes that interpolate linearly; sine and zero come from the package.
  localparam logic [1:0] MODE_LINEAR     = 2'b00;
  localparam logic [1:0] MODE_LINEAR_ALT = 2'b11;

  typedef enum logic {REQ_WRITE = 1'b0, REQ_EVAL = 1'b1} req_kind_t;

  typedef struct {
    req_kind_t   kind;
    logic [3:0]  slot;
    logic [15:0] amount;
    logic [15:0] word;
    logic [15:0] query;
  } curve_req_t;

  // Curve model and store of expected curve values, oldest first.
  class curve_scoreboard_t;
    logic [15:0] pt_amount [16];
    logic [15:0] pt_word [16];
    logic [4:0]  point_count;
    logic [16:0] sine_q16 [257];
    logic [21:0] expected_values [int];
    int          wr_ptr;
    int          rd_ptr;
    int          errors;

    function new();
      logic [63:0] x, xx, acc, prod, c;
      point_count = '0;
      errors = 0;
      wr_ptr = 0;
      rd_ptr = 0;
      foreach (pt_amount[k]) begin
        pt_amount[k] = '0;
        pt_word[k] = '0;
      end
      // Quarter-sine table from the nested odd polynomial, Q32 coefficients.
      for (int k = 0; k <= 256; k++) begin
        x = 64'(k) * 64'd256;
        xx = (x * x) >> 16;
        acc = 64'd689072;
        for (int s = 0; s < 4; s++) begin
          case (s)
            0: c = 64'd20107981;
            1: c = 64'd342277197;
            2: c = 64'd2774394673;
            default: c = 64'd6746518852;
          endcase
          prod = (xx * acc) >> 16;
          acc = (c > prod) ? c - prod : 64'd0;
        end
        acc = (acc * x) >> 32;
        sine_q16[k] = (acc > 64'd65536) ? 17'd65536 : acc[16:0];
      end
    endfunction

    // Number of expected values still waiting for a result transfer.
    function int pending();
      return wr_ptr - rd_ptr;
    endfunction

    function logic [16:0] quarter_sine(logic [15:0] ratio);
      logic [16:0] lo, hi;
      logic [63:0] step;
      lo = sine_q16[ratio[15:8]];
      hi = sine_q16[int'(ratio[15:8]) + 1];
      if (hi < lo) return lo;
      step = (64'(hi - lo) * 64'({ratio[7:0], 8'h00})) >> 16;
      return lo + step[16:0];
    endfunction

    function logic [21:0] mix_values(logic [13:0] v1, logic [13:0] v2, logic [16:0] f);
      logic [63:0] acc;
      acc = 64'(v1) << 24;
      if (v2 >= v1) acc = acc + 64'(v2 - v1) * 64'(f);
      else acc = acc - 64'(v1 - v2) * 64'(f);
      return acc[37:16];
    endfunction

    function logic [21:0] curve_at(logic [15:0] q);
      int          n, i;
      logic [15:0] a, b;
      logic [31:0] ratio;
      logic [13:0] v1, v2;
      n = (point_count > 5'd16) ? 16 : int'(point_count);
      if (n == 0) return '0;
      if (q <= pt_amount[0]) return {pt_word[0][13:0], 8'h00};
      if (q >= pt_amount[n-1]) return {pt_word[n-1][13:0], 8'h00};
      // Walk to the segment whose start is the last amount not above the query.
      i = 0;
      while (i + 1 < n - 1 && q >= pt_amount[i+1]) i++;
      a = pt_amount[i];
      b = pt_amount[i+1];
      if (b <= a || q < a) return '0;
      ratio = (32'(q - a) << 16) / 32'(b - a);
      v1 = pt_word[i][13:0];
      v2 = pt_word[i+1][13:0];
      case (pt_word[i+1][15:14])
        bcv_pkg::MODE_SINE: return mix_values(v1, v2, quarter_sine(ratio[15:0]));
        bcv_pkg::MODE_ZERO: return '0;
        default: return mix_values(v1, v2, {1'b0, ratio[15:0]});
      endcase
    endfunction

    function void note_input(curve_req_t rq);
      if (rq.kind == REQ_WRITE) begin
        pt_amount[rq.slot] = rq.amount;
        pt_word[rq.slot] = rq.word;
      end else begin
        expected_values[wr_ptr] = curve_at(rq.query);
        wr_ptr++;
      end
    endfunction

    function void check_result(logic [21:0] actual);
      logic [21:0] want;
      if (pending() == 0) begin
        errors++;
        $display("%0t: curve value mismatch, expected none actual %0d", $time, actual);
        return;
      end
      want = expected_values[rd_ptr];
      expected_values.delete(rd_ptr);
      rd_ptr++;
      if (actual !== want) begin
        errors++;
        $display("%0t: curve value mismatch, expected %0d actual %0d", $time, want, actual);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_req_type = 1'b0;
  logic [3:0]  in_point_index = '0;
  logic [15:0] in_point_amount = '0;
  logic [15:0] in_point_word = '0;
  logic [15:0] in_query_amount = '0;
  logic        out_strobe;
  logic [21:0] out_curve_value;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;

  curve_scoreboard_t sb = new();
  bit                quiet = 1'b0;
  int                items_sent = 0;

  breakpoint_curve_evaluator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_point_index  (in_point_index),
    .in_point_amount (in_point_amount),
    .in_point_word   (in_point_word),
    .in_query_amount (in_query_amount),
    .out_strobe      (out_strobe),
    .out_curve_value (out_curve_value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Every strobed result is checked against the oldest expected value.
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) sb.check_result(out_curve_value);
  end

  function automatic curve_req_t write_req(logic [3:0] slot, logic [15:0] amount,
                                           logic [15:0] word);
    curve_req_t rq;
    rq.kind = REQ_WRITE;
    rq.slot = slot;
    rq.amount = amount;
    rq.word = word;
    rq.query = 16'($urandom);
    return rq;
  endfunction

  function automatic curve_req_t eval_req(logic [15:0] query);
    curve_req_t rq;
    rq.kind = REQ_EVAL;
    rq.slot = 4'($urandom);
    rq.amount = 16'($urandom);
    rq.word = 16'($urandom);
    rq.query = query;
    return rq;
  endfunction

  // Holds one request on the input ports until the block takes the transfer.
  task automatic send_request(curve_req_t rq);
    @(negedge clk);
    start <= 1'b1;
    in_req_type <= rq.kind;
    in_point_index <= rq.slot;
    in_point_amount <= rq.amount;
    in_point_word <= rq.word;
    in_query_amount <= rq.query;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_input(rq);
  endtask

  // Sender idles; the payload ports carry junk that the block must ignore.
  task automatic pause_sender(int cycles);
    @(negedge clk);
    start <= 1'b0;
    in_req_type <= 1'($urandom);
    in_point_amount <= 16'($urandom);
    in_query_amount <= 16'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic issue(curve_req_t rq);
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) pause_sender($urandom_range(1, 45));
    send_request(rq);
    items_sent++;
  endtask

  // Waits for every expected value, then lets a write in flight finish.
  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_point_count(logic [4:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.point_count = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int          phase, cnt, n, len, sel, style, base, top, amt;
    logic [1:0]  mode;
    logic [15:0] word, q;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty curve, then a four-point curve with every segment mode.
    issue(eval_req(16'h0000));
    issue(eval_req(16'hFFFF));
    issue(write_req(4'd0, 16'd100, {MODE_LINEAR, 14'h3FFF}));
    issue(write_req(4'd1, 16'd1000, {bcv_pkg::MODE_SINE, 14'h0000}));
    issue(write_req(4'd2, 16'd2000, {bcv_pkg::MODE_ZERO, 14'h1234}));
    issue(write_req(4'd3, 16'hFFFF, {MODE_LINEAR_ALT, 14'h3FFF}));
    set_point_count(5'd4);
    issue(eval_req(16'd0));
    issue(eval_req(16'd100));
    issue(eval_req(16'd101));
    issue(eval_req(16'd500));
    issue(eval_req(16'd999));
    issue(eval_req(16'd1000));
    issue(eval_req(16'd1500));
    issue(eval_req(16'd2000));
    issue(eval_req(16'd30000));
    issue(eval_req(16'hFFFE));
    issue(eval_req(16'hFFFF));

    // Random phases, each under its own point count; the first ones hit the extremes.
    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case (phase)
        0: cnt = 16;
        1: cnt = 31;
        2: cnt = 17;
        3: cnt = 1;
        4: cnt = 2;
        5: cnt = 0;
        default: cnt = ($urandom_range(0, 1) != 0) ? $urandom_range(2, 16) : $urandom_range(0, 31);
      endcase
      set_point_count(5'(cnt));
      quiet = (phase >= 6 && phase < 9);

      // Rebuild all sixteen points in ascending order; some styles allow flat steps.
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        style = $urandom_range(0, 3);
        base = (style == 0) ? 0 : $urandom_range(0, 3000);
        case (style)
          1: top = 65535;
          3: top = base + $urandom_range(15, 120);
          default: top = $urandom_range(base + 200, 65535);
        endcase
        amt = base;
        for (int k = 0; k < 16; k++) begin
          if (k == 15 && style == 1) amt = 65535;
          mode = 2'($urandom);
          case ($urandom_range(0, 5))
            0: word = {mode, 14'h3FFF};
            1: word = {mode, 14'h0000};
            default: word = 16'($urandom);
          endcase
          issue(write_req(4'(k), 16'(amt), word));
          amt = amt + $urandom_range((style == 2) ? 0 : 1, (top - base) / 15);
          if (amt > 65535) amt = 65535;
        end
      end

      // Mostly evaluations inside the curve, some on and beside breakpoints,
      // and a few stray writes that may leave the amounts unsorted.
      n = (cnt > 16) ? 16 : cnt;
      len = $urandom_range(30, 110);
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(0, 99) < 12) begin
          issue(write_req(4'($urandom), 16'($urandom), 16'($urandom)));
        end else begin
          sel = $urandom_range(0, 9);
          if (n == 0 || sel == 0) q = 16'($urandom);
          else if (sel == 1) q = sb.pt_amount[$urandom_range(0, n - 1)];
          else if (sel == 2) q = sb.pt_amount[$urandom_range(0, n - 1)] +
                                 (($urandom_range(0, 1) != 0) ? 16'd1 : 16'hFFFF);
          else q = 16'($urandom_range(sb.pt_amount[0], sb.pt_amount[n-1]));
          issue(eval_req(q));
        end
      end
      phase++;
    end

    drain();
    if (sb.pending() != 0) begin
      $display("%0t: %0d curve value(s) never arrived", $time, sb.pending());
      sb.errors += sb.pending();
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
